### rtl/nibble_token_stream_packer_core_defines.svh
// Assertion macros shared by the packer checker.
`ifndef NIBBLE_TOKEN_STREAM_PACKER_CORE_DEFINES_SVH
`define NIBBLE_TOKEN_STREAM_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, idle while reset is high.
`define NTSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while reset is high.
`define NTSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ntsp_pkg.sv
`default_nettype none
package ntsp_pkg;

  // Command codes
  localparam logic [1:0] CMD_TOKEN   = 2'd0;
  localparam logic [1:0] CMD_LITERAL = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;

  // Token cases that carry fields after the case nibble
  localparam logic [3:0] CASE_RAW_LEN = 4'd0;
  localparam logic [3:0] CASE_SHORT_3 = 4'd3;
  localparam logic [3:0] CASE_SHORT_4 = 4'd4;
  localparam logic [3:0] CASE_SHORT_5 = 4'd5;
  localparam logic [3:0] CASE_ARG_LO  = 4'd9;
  localparam logic [3:0] CASE_OFS_8   = 4'd10;
  localparam logic [3:0] CASE_OFS_12  = 4'd11;
  localparam logic [3:0] CASE_OFS_16  = 4'd12;
  localparam logic [3:0] CASE_ARG_HI  = 4'd15;

  localparam logic [3:0] LEN_BIAS = 4'd3;

  // Most nibbles one item can carry (a token with a 16-bit offset)
  localparam int NIBS_MAX = 6;

  localparam int LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // Register indexes
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  typedef struct packed {
    logic                         finish;
    logic [2:0]                   count;
    logic [NIBS_MAX-1:0][3:0]     nibs;
  } ntsp_entry_t;

endpackage
`default_nettype wire

### rtl/ntsp_in_if.sv
`default_nettype none
interface ntsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  case_code;
  logic [4:0]  run_length;
  logic [15:0] offset_arg;
  logic [7:0]  literal;

  modport source(output valid, cmd, case_code, run_length, offset_arg, literal,
                 input ready);
  modport sink(input valid, cmd, case_code, run_length, offset_arg, literal,
               output ready);
endinterface
`default_nettype wire

### rtl/ntsp_out_if.sv
`default_nettype none
interface ntsp_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       overflow;
  logic       last;

  modport source(output valid, byte_valid, out_byte, overflow, last, input ready);
  modport sink(input valid, byte_valid, out_byte, overflow, last, output ready);
endinterface
`default_nettype wire

### rtl/ntsp_front.sv
`default_nettype none
module ntsp_front (
  input  wire logic [1:0]         cmd,
  input  wire logic [3:0]         case_code,
  input  wire logic [4:0]         run_length,
  input  wire logic [15:0]        offset_arg,
  input  wire logic [7:0]         literal,
  output ntsp_pkg::ntsp_entry_t   entry
);
  import ntsp_pkg::*;

  logic [3:0] len_m3;

  assign len_m3 = run_length[3:0] - LEN_BIAS;

  // Turn one item into its ordered list of nibbles
  always_comb begin
    entry = '0;
    case (cmd)
      CMD_TOKEN: begin
        entry.nibs[0] = case_code;
        entry.count   = 3'd1;
        case (case_code)
          CASE_RAW_LEN: begin
            entry.nibs[1] = run_length[3:0];
            entry.count   = 3'd2;
          end
          CASE_SHORT_3, CASE_SHORT_4, CASE_SHORT_5: begin
            entry.nibs[1] = len_m3;
            entry.count   = 3'd2;
          end
          CASE_ARG_LO, CASE_ARG_HI: begin
            entry.nibs[1] = offset_arg[3:0];
            entry.count   = 3'd2;
          end
          CASE_OFS_8: begin
            entry.nibs[1] = len_m3;
            entry.nibs[2] = offset_arg[7:4];
            entry.nibs[3] = offset_arg[3:0];
            entry.count   = 3'd4;
          end
          CASE_OFS_12: begin
            entry.nibs[1] = len_m3;
            entry.nibs[2] = offset_arg[11:8];
            entry.nibs[3] = offset_arg[7:4];
            entry.nibs[4] = offset_arg[3:0];
            entry.count   = 3'd5;
          end
          CASE_OFS_16: begin
            entry.nibs[1] = len_m3;
            entry.nibs[2] = offset_arg[15:12];
            entry.nibs[3] = offset_arg[11:8];
            entry.nibs[4] = offset_arg[7:4];
            entry.nibs[5] = offset_arg[3:0];
            entry.count   = 3'd6;
          end
          default: begin
            entry.count = 3'd1;
          end
        endcase
      end
      CMD_LITERAL: begin
        entry.nibs[0] = literal[7:4];
        entry.nibs[1] = literal[3:0];
        entry.count   = 3'd2;
      end
      CMD_FINISH: begin
        // zero byte; the back end adds the pad nibble when half full
        entry.count  = 3'd2;
        entry.finish = 1'b1;
      end
      default: begin
        entry.count = 3'd0;
      end
    endcase
  end
endmodule
`default_nettype wire

### rtl/ntsp_queue.sv
`default_nettype none
module ntsp_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  ntsp_pkg::ntsp_entry_t      push_entry,
  output logic                       not_full,
  input  wire logic                  pop,
  output ntsp_pkg::ntsp_entry_t      pop_entry,
  output logic                       not_empty
);
  import ntsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ntsp_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign not_full  = (fill != CNT_FULL);
  assign not_empty = (fill != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/ntsp_back.sv
`default_nettype none
module ntsp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ntsp_pkg::LIMIT_W-1:0]  limit,
  input  wire logic                          entry_valid,
  input  ntsp_pkg::ntsp_entry_t              entry,
  output logic                               entry_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               byte_valid,
  output logic [7:0]                         out_byte,
  output logic                               overflow,
  output logic                               last
);
  import ntsp_pkg::*;

  // Stream state
  logic [LIMIT_W-1:0] bytes_written;
  logic               half_full;
  logic [3:0]         pending_high_nibble;
  logic               overflow_seen;

  // Result job being handed out
  logic               job_valid;
  logic [2:0][7:0]    job_bytes;
  logic [1:0]         job_count;
  logic [1:0]         job_idx;
  logic               job_flag;

  logic [LIMIT_W:0]   diff;
  logic [2:0]         room;
  logic [3:0]         cap;
  logic [2:0]         n_eff;
  logic               too_many;
  logic [2:0]         w;
  logic [2:0]         t;
  logic [3:0]         s [7];
  logic [3:0]         tail;
  logic [2:0][7:0]    new_bytes;
  logic               job_last;

  // Byte room left before the limit, capped: an item never needs more than 4
  assign diff = {1'b0, limit} - {1'b0, bytes_written};

  always_comb begin
    if (diff[LIMIT_W] || diff == '0) begin
      room = 3'd0;
    end else if (diff[LIMIT_W-1:2] != '0) begin
      room = 3'd4;
    end else begin
      room = {1'b0, diff[1:0]};
    end
  end

  assign cap      = (room == 3'd0) ? 4'd0 : {room, 1'b0} - {3'd0, half_full};
  assign n_eff    = entry.count + {2'd0, entry.finish & half_full};
  assign too_many = ({1'b0, n_eff} > cap);
  assign w        = overflow_seen ? 3'd0 : (too_many ? cap[2:0] : n_eff);
  assign t        = w + {2'd0, half_full};

  // Nibble stream of this item, with the held high nibble in front
  always_comb begin
    s[0] = half_full ? pending_high_nibble : entry.nibs[0];
    for (int i = 1; i < NIBS_MAX; i++) begin
      s[i] = half_full ? entry.nibs[i-1] : entry.nibs[i];
    end
    s[6] = half_full ? entry.nibs[NIBS_MAX-1] : 4'd0;
    for (int j = 0; j < 3; j++) begin
      new_bytes[j] = {s[2*j], s[2*j+1]};
    end
    case (t)
      3'd1:    tail = s[0];
      3'd3:    tail = s[2];
      3'd5:    tail = s[4];
      3'd7:    tail = s[6];
      default: tail = pending_high_nibble;
    endcase
  end

  assign job_last  = (job_count == 2'd0) || (job_idx == job_count - 2'd1);
  assign entry_pop = entry_valid && (!job_valid || (out_ready && job_last));

  assign out_valid  = job_valid;
  assign byte_valid = (job_count != 2'd0);
  assign out_byte   = byte_valid ? job_bytes[job_idx] : 8'd0;
  assign overflow   = job_flag;
  assign last       = job_last;

  always_ff @(posedge clk) begin
    if (entry_pop) begin
      job_bytes <= new_bytes;
      job_count <= t[2:1];
      job_flag  <= overflow_seen | too_many;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written       <= '0;
      half_full           <= 1'b0;
      pending_high_nibble <= 4'd0;
      overflow_seen       <= 1'b0;
      job_valid           <= 1'b0;
      job_idx             <= 2'd0;
    end else begin
      if (entry_pop) begin
        if (entry.finish) begin
          bytes_written       <= '0;
          half_full           <= 1'b0;
          pending_high_nibble <= 4'd0;
          overflow_seen       <= 1'b0;
        end else begin
          bytes_written       <= bytes_written + LIMIT_W'(t[2:1]);
          half_full           <= t[0];
          pending_high_nibble <= t[0] ? tail : pending_high_nibble;
          overflow_seen       <= overflow_seen | too_many;
        end
      end
      if (entry_pop) begin
        job_valid <= 1'b1;
        job_idx   <= 2'd0;
      end else if (job_valid && out_ready) begin
        if (job_last) begin
          job_valid <= 1'b0;
        end else begin
          job_idx <= job_idx + 2'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/nibble_token_stream_packer_core.sv
`default_nettype none
// Channel   Dir  Payload                                        Moves
// tokens    in   cmd, case_code, run_length, offset_arg, literal one item per command
// stream    out  byte_valid, out_byte, overflow, last           one item per result
//
// Each input item yields max(1, bytes completed) output items, one per cycle
// while the receiver is ready. A new item enters the queue every cycle while
// the queue has room, also while results wait.
// Reset (rst, synchronous) empties the queue, drops any result, clears the
// stream state and sets output_limit to 65536. No clearing pass.
module nibble_token_stream_packer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ntsp_in_if.sink          tokens,
  ntsp_out_if.source       stream,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ntsp_pkg::*;

  logic [LIMIT_W-1:0] output_limit;
  ntsp_entry_t        front_entry;
  ntsp_entry_t        queue_entry;
  logic               queue_not_full;
  logic               queue_not_empty;
  logic               queue_pop;
  logic               push;
  logic               cfg_write;

  // Configuration: one register at byte address 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_LIMIT);
  assign prdata    = (paddr[2] == REG_OUTPUT_LIMIT) ?
                     {{(32-LIMIT_W){1'b0}}, output_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      output_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Front: classify the item into its nibble list
  ntsp_front u_front (
    .cmd        (tokens.cmd),
    .case_code  (tokens.case_code),
    .run_length (tokens.run_length),
    .offset_arg (tokens.offset_arg),
    .literal    (tokens.literal),
    .entry      (front_entry)
  );

  // Accept whenever the queue has a free slot
  assign tokens.ready = queue_not_full;
  assign push         = tokens.valid && queue_not_full;

  ntsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .not_full   (queue_not_full),
    .pop        (queue_pop),
    .pop_entry  (queue_entry),
    .not_empty  (queue_not_empty)
  );

  // Back: apply limit check, pack nibbles, hand out result items
  ntsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .limit       (output_limit),
    .entry_valid (queue_not_empty),
    .entry       (queue_entry),
    .entry_pop   (queue_pop),
    .out_valid   (stream.valid),
    .out_ready   (stream.ready),
    .byte_valid  (stream.byte_valid),
    .out_byte    (stream.out_byte),
    .overflow    (stream.overflow),
    .last        (stream.last)
  );
endmodule
`default_nettype wire

### rtl/ntsp_checker.sv
`default_nettype none
`include "nibble_token_stream_packer_core_defines.svh"
module ntsp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       byte_valid,
  input wire logic [7:0] out_byte,
  input wire logic       overflow,
  input wire logic       last,
  input wire logic       pready
);
  `NTSP_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last), "stalled result changed")
  `NTSP_ASSERT_SAME(a_empty_result, clk, rst, out_valid && !byte_valid, out_byte == 8'd0 && last, "empty result not zero or not last")
  `NTSP_ASSERT_NEXT(a_item_flag, clk, rst, out_valid && out_ready && !last, out_valid && $stable(overflow), "result run broken or flag changed within item")
  `NTSP_ASSERT_SAME(a_pready, clk, rst, 1'b1, pready, "pready dropped")
endmodule

bind nibble_token_stream_packer_core ntsp_checker u_ntsp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (stream.valid),
  .out_ready  (stream.ready),
  .byte_valid (stream.byte_valid),
  .out_byte   (stream.out_byte),
  .overflow   (stream.overflow),
  .last       (stream.last),
  .pready     (pready)
);
`default_nettype wire

### sim/nibble_token_stream_packer_core_checker.sv
`timescale 1ns / 1ps
module nibble_token_stream_packer_core_checker (
  input  logic        clk,
  input  logic        rst,
  ntsp_in_if          tokens,
  ntsp_out_if         stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          mismatches
);
  import ntsp_pkg::*;

  localparam logic [2:0] LIMIT_ADDR = {REG_OUTPUT_LIMIT, 2'b00};
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       overflow;
    logic       last;
  } stream_beat_t;

  stream_beat_t stream_exp_q[$];
  stream_beat_t got_beat;
  stream_beat_t want_beat;

  // Shadow of the packer state
  logic [LIMIT_W-1:0] out_limit;
  logic [LIMIT_W-1:0] bytes_out;
  logic               half_full;
  logic [3:0]         high_nib;
  logic               ovf_flag;
  logic [7:0]         done_bytes[$];

  // Drop the nibble once the flag is up or the byte limit is reached.
  function void put_nib(input logic [3:0] nib);
    if (!ovf_flag) begin
      if (bytes_out >= out_limit) begin
        ovf_flag = 1'b1;
      end else if (!half_full) begin
        high_nib  = nib;
        half_full = 1'b1;
      end else begin
        done_bytes.push_back({high_nib, nib});
        bytes_out = bytes_out + 1'b1;
        half_full = 1'b0;
      end
    end
  endfunction

  function void put_byte(input logic [7:0] b);
    put_nib(b[7:4]);
    put_nib(b[3:0]);
  endfunction

  function void pack_item(input logic [1:0] cmd, input logic [3:0] code,
                          input logic [4:0] len, input logic [15:0] arg,
                          input logic [7:0] lit);
    logic [3:0]   len_m3;
    logic         flag;
    int           n;
    stream_beat_t beat;
    done_bytes.delete();
    len_m3 = len[3:0] - LEN_BIAS;
    case (cmd)
      CMD_TOKEN: begin
        put_nib(code);
        case (code)
          CASE_RAW_LEN: put_nib(len[3:0]);
          CASE_SHORT_3, CASE_SHORT_4, CASE_SHORT_5: put_nib(len_m3);
          CASE_ARG_LO, CASE_ARG_HI: put_nib(arg[3:0]);
          CASE_OFS_8: begin
            put_nib(len_m3);
            put_byte(arg[7:0]);
          end
          CASE_OFS_12: begin
            put_nib(len_m3);
            put_byte(arg[11:4]);
            put_nib(arg[3:0]);
          end
          CASE_OFS_16: begin
            put_nib(len_m3);
            put_byte(arg[15:8]);
            put_byte(arg[7:0]);
          end
          default: ;
        endcase
      end
      CMD_LITERAL: put_byte(lit);
      CMD_FINISH: begin
        put_byte(8'h00);
        if (half_full) put_nib(4'h0);
      end
      default: ;
    endcase
    flag = ovf_flag;
    if (cmd == CMD_FINISH) begin
      half_full = 1'b0;
      high_nib  = 4'h0;
      bytes_out = '0;
      ovf_flag  = 1'b0;
    end
    n = (done_bytes.size() > 3) ? 3 : done_bytes.size();
    if (n == 0) begin
      beat = '{byte_valid: 1'b0, out_byte: 8'h00, overflow: flag, last: 1'b1};
      stream_exp_q.push_back(beat);
    end
    for (int k = 0; k < n; k++) begin
      beat = '{byte_valid: 1'b1, out_byte: done_bytes[k], overflow: flag,
               last: (k == n - 1)};
      stream_exp_q.push_back(beat);
    end
  endfunction

  function void note_mismatch(input stream_beat_t want, input stream_beat_t got,
                              input bit none_waiting);
    if (mismatches < MAX_REPORTS) begin
      if (none_waiting)
        $display("%0t: unexpected item: byte_valid=%0d out_byte=%02h overflow=%0d last=%0d",
                 $time, got.byte_valid, got.out_byte, got.overflow, got.last);
      else
        $display("%0t: mismatch: exp byte_valid=%0d out_byte=%02h overflow=%0d last=%0d, got byte_valid=%0d out_byte=%02h overflow=%0d last=%0d",
                 $time, want.byte_valid, want.out_byte, want.overflow, want.last,
                 got.byte_valid, got.out_byte, got.overflow, got.last);
    end
    mismatches = mismatches + 1;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_limit = LIMIT_RESET;
      bytes_out = '0;
      half_full = 1'b0;
      high_nib  = 4'h0;
      ovf_flag  = 1'b0;
      stream_exp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        out_limit = pwdata[LIMIT_W-1:0];
      if (stream.valid && stream.ready) begin
        got_beat = '{byte_valid: stream.byte_valid, out_byte: stream.out_byte,
                     overflow: stream.overflow, last: stream.last};
        if (stream_exp_q.size() == 0) begin
          note_mismatch(got_beat, got_beat, 1'b1);
        end else begin
          want_beat = stream_exp_q.pop_front();
          if (got_beat.byte_valid !== want_beat.byte_valid ||
              got_beat.out_byte !== want_beat.out_byte ||
              got_beat.overflow !== want_beat.overflow ||
              got_beat.last !== want_beat.last)
            note_mismatch(want_beat, got_beat, 1'b0);
        end
      end
      if (tokens.valid && tokens.ready)
        pack_item(tokens.cmd, tokens.case_code, tokens.run_length,
                  tokens.offset_arg, tokens.literal);
    end
    pending <= stream_exp_q.size();
  end

endmodule

### sim/nibble_token_stream_packer_core_tb.sv
`timescale 1ns / 1ps
module nibble_token_stream_packer_core_tb;
  import ntsp_pkg::*;

  // cmd 3 is not a command; the block must answer with an empty result
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] LIMIT_ADDR = {REG_OUTPUT_LIMIT, 2'b00};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int STALL_CYCLES   = 90;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 29;
  localparam int NUM_PHASES     = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int mismatches;
  int items_sent = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 85;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  ntsp_in_if  tokens();
  ntsp_out_if stream();

  nibble_token_stream_packer_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .tokens  (tokens),
    .stream  (stream),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scoreboard: predicts every result from the accepted items and compares
  nibble_token_stream_packer_core_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .tokens     (tokens),
    .stream     (stream),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // that the internal queue fills up and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      stream.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken   <= hold_asked;
      hold_left    <= STALL_CYCLES;
      stream.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      stream.ready <= 1'b0;
    end else begin
      stream.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (tokens.valid && tokens.ready) || (stream.valid && stream.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("nibble_token_stream_packer_core_tb: FAIL");
        $finish;
      end
    end
  end

  // Offer one item, after a random gap, and hold it until it is accepted.
  // Call right after a rising edge.
  task automatic send_item(input logic [1:0] cmd, input logic [3:0] code,
                           input logic [4:0] len, input logic [15:0] arg,
                           input logic [7:0] lit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tokens.valid <= 1'b0;
      @(posedge clk);
    end
    tokens.valid      <= 1'b1;
    tokens.cmd        <= cmd;
    tokens.case_code  <= code;
    tokens.run_length <= len;
    tokens.offset_arg <= arg;
    tokens.literal    <= lit;
    @(posedge clk);
    while (!tokens.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send an item of the given command with random content; lengths stay
  // mostly in the legal 1..18 band, with a few taken over the full width.
  task automatic send_random(input logic [1:0] cmd);
    logic [3:0]  code;
    logic [4:0]  len;
    logic [15:0] arg;
    logic [7:0]  lit;
    code = 4'($urandom);
    len  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                                          5'($urandom_range(1, 18));
    arg  = 16'($urandom);
    lit  = 8'($urandom);
    send_item(cmd, code, len, arg, lit);
  endtask

  // One stream: a short header of literal bytes, a body of tokens and
  // literals, then a finish. A few bodies carry an unused command or an
  // early finish, and a few streams are left open into the next one.
  task automatic send_stream();
    int n_hdr;
    int n_body;
    int pick;
    n_hdr  = $urandom_range(0, 3);
    n_body = $urandom_range(2, 9);
    repeat (n_hdr) send_random(CMD_LITERAL);
    repeat (n_body) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      send_random(CMD_TOKEN);
      else if (pick < 92) send_random(CMD_LITERAL);
      else if (pick < 96) send_random(CMD_UNUSED);
      else                send_random(CMD_FINISH);
    end
    if ($urandom_range(0, 9) != 0) send_random(CMD_FINISH);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid and wait until every expected result has come back, then
  // let the pipeline settle before touching the register.
  task automatic wait_idle();
    tokens.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    // Byte limits per phase: none at all, tight ones that overflow inside a
    // stream, the widest the register holds, and the reset value back again.
    int limits[NUM_PHASES];
    int goal;
    limits = '{0, 5, 17, 131071, 24, 65536};

    tokens.valid      = 1'b0;
    tokens.cmd        = CMD_TOKEN;
    tokens.case_code  = 4'h0;
    tokens.run_length = 5'd0;
    tokens.offset_arg = 16'h0000;
    tokens.literal    = 8'h00;
    stream.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = 3'd0;
    pwdata            = 32'd0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of every field and every token case at the reset
    // limit, then an odd nibble count padded by finish and an empty finish.
    send_item(CMD_LITERAL, 4'h0, 5'd0, 16'h0000, 8'h00);
    send_item(CMD_LITERAL, 4'hF, 5'd31, 16'hFFFF, 8'hFF);
    send_item(CMD_TOKEN, CASE_RAW_LEN, 5'd31, 16'h0000, 8'h00);
    send_item(CMD_TOKEN, CASE_RAW_LEN, 5'd0, 16'h0000, 8'h00);
    for (int c = 1; c < 16; c++) begin
      // hold the short lengths at their wrap points: 1 wraps below the bias
      send_item(CMD_TOKEN, 4'(c), (c % 2 == 0) ? 5'd1 : 5'd18,
                (c % 2 == 0) ? 16'hFFFF : 16'hA5C3, 8'h00);
    end
    send_item(CMD_TOKEN, CASE_OFS_16, 5'd3, 16'h0000, 8'h00);
    send_item(CMD_UNUSED, 4'hF, 5'd31, 16'hFFFF, 8'hFF);
    send_item(CMD_TOKEN, CASE_SHORT_3 - 4'd2, 5'd5, 16'h0000, 8'h00);
    send_item(CMD_FINISH, 4'h0, 5'd0, 16'h0000, 8'h00);
    send_item(CMD_FINISH, 4'h0, 5'd0, 16'h0000, 8'h00);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(LIMIT_ADDR, limits[ph]);
      // idle mix: light sender gaps and a slow receiver, then the reverse,
      // then full rate on both sides
      case (ph / 2)
        0: begin
          send_idle_pct <= 14;
          recv_idle_pct <= 85;
        end
        1: begin
          send_idle_pct <= 85;
          recv_idle_pct <= 14;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      // hold off the receiver while the sender keeps offering at full rate
      if (ph == 4) hold_asked <= hold_asked + 1;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_stream();
    end

    tokens.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("nibble_token_stream_packer_core_tb: PASS");
    end else begin
      $display("nibble_token_stream_packer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
